### src/qtoc_pkg.sv
// qtoc_pkg: sizes, codes, transaction types and helpers of the quadtree
// occupancy counter. No dependencies; imported by the cell, the top level and the checker.

package qtoc_pkg;

  // Tree and count sizing
  localparam int MAX_LEVELS   = 6;
  localparam int COUNT_BITS   = 16;
  localparam int TOTAL_NODES  = ((1 << (2 * MAX_LEVELS)) - 1) / 3;

  // Fixed field widths
  localparam int ACT_W        = 2;
  localparam int IDX_W        = 11;
  localparam int CFG_W        = 3;
  localparam int NODE_COUNT_W = 16;
  localparam int ERR_W        = 2;

  // Internal widths
  localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int OFF_W = (MAX_LEVELS > 1) ? 2 * (MAX_LEVELS - 1) : 1;

  localparam logic [CFG_W-1:0]      LEVELS_RESET = CFG_W'(6);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

  // Action codes; any other code reads
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] node_index;
  } in_item_t;

  typedef struct packed {
    logic [NODE_COUNT_W-1:0] node_count;
    logic [ERR_W-1:0]        error_code;
  } out_item_t;

  // Token handed from cell to cell, deepest level first
  typedef struct packed {
    logic                    valid;
    logic [ACT_W-1:0]        action;
    logic                    first;   // named node not yet visited
    logic [LVL_W-1:0]        skip;    // cells to pass before the named level
    logic [OFF_W-1:0]        offset;  // position within the current level
    logic [ERR_W-1:0]        err;
    logic [NODE_COUNT_W-1:0] count;
  } tok_t;

  // Write request of one cell to its level memory
  typedef struct packed {
    logic                  we;
    logic [OFF_W-1:0]      addr;
    logic [COUNT_BITS-1:0] data;
  } ram_wr_t;

  // Clamp a count to the width of the result field
  function automatic logic [NODE_COUNT_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
    logic [NODE_COUNT_W-1:0] r;
    if (COUNT_BITS > NODE_COUNT_W) begin
      if (c > COUNT_BITS'({NODE_COUNT_W{1'b1}})) r = {NODE_COUNT_W{1'b1}};
      else r = NODE_COUNT_W'(c);
    end else begin
      r = NODE_COUNT_W'(c);
    end
    return r;
  endfunction

endpackage

### src/qtoc_ram.sv
// qtoc_ram: generic single-write, single-read memory with registered read data.
// No dependencies; one instance holds the counts of one tree level.

module qtoc_ram #(
  parameter int DW = 16,
  parameter int AW = 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [0:(1 << AW)-1];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/qtoc_cell.sv
// qtoc_cell: one level of the counter chain. Holds the token for its level,
// updates that level's count and passes the token on. Depends on qtoc_pkg.

module qtoc_cell
  import qtoc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tok_t                  tok_i,
  input  logic [COUNT_BITS-1:0] rdata_i,
  output logic [OFF_W-1:0]      raddr_o,
  output tok_t                  tok_o,
  output ram_wr_t               wr_o
);

  tok_t                  tok_q;
  logic [COUNT_BITS-1:0] new_cnt;

  // Read is issued as the token arrives, data is ready while the token sits here
  assign raddr_o = tok_i.offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // Read-modify-write of this level's count; skipping and errored tokens pass without a write
  always_comb begin
    tok_o   = tok_q;
    new_cnt = rdata_i;
    wr_o.we   = 1'b0;
    wr_o.addr = tok_q.offset;
    wr_o.data = rdata_i;
    if (tok_q.valid && (tok_q.skip != '0)) begin
      tok_o.skip = tok_q.skip - LVL_W'(1);
    end else if (tok_q.valid) begin
      tok_o.offset = tok_q.offset >> 2;
      if (tok_q.err == ERR_OK) begin
        if (tok_q.first && (tok_q.action == ACT_REMOVE) && (rdata_i == '0)) begin
          tok_o.err   = ERR_EMPTY;
          tok_o.count = '0;
          tok_o.first = 1'b0;
        end else begin
          if (tok_q.action == ACT_ADD) begin
            new_cnt = (rdata_i == COUNT_MAX) ? rdata_i : rdata_i + COUNT_BITS'(1);
            wr_o.we = 1'b1;
          end else if (tok_q.action == ACT_REMOVE) begin
            new_cnt = (rdata_i == '0) ? rdata_i : rdata_i - COUNT_BITS'(1);
            wr_o.we = 1'b1;
          end
          wr_o.data = new_cnt;
          if (tok_q.first) begin
            tok_o.count = clamp_count(new_cnt);
            tok_o.first = 1'b0;
          end
        end
      end
    end
  end

endmodule

### src/quadtree_occupancy_counter_unit.sv
// quadtree_occupancy_counter_unit: top level. Range check and level decode,
// chain of level cells with their memories, result buffering.
// Depends on qtoc_pkg, qtoc_cell and qtoc_ram.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i             | cfg_wdata_i (levels_in_use)
//
// Each transaction walks the chain of MAX_LEVELS cells, deepest level first,
// one cell per cycle; the result is registered behind the root cell. A new
// transaction waits for the last to leave the chain and for a free buffer.
// After reset a clearing pass zeroes all level memories; inputs are stalled
// meanwhile, configuration writes are taken.
// A stalled result is held; one further result is buffered behind it.

module quadtree_occupancy_counter_unit
  import qtoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [OFF_W-1:0] clr_cnt_q;
  logic [CFG_W-1:0] cfg_q;
  logic             accept;
  logic             clearing;
  tok_t             entry_tok;
  tok_t             res_tok;
  out_item_t        out_q, pend_q;
  logic             out_valid_q, pend_valid_q;
  logic             out_take;

  tok_t    chain_out [MAX_LEVELS];
  ram_wr_t cell_wr   [MAX_LEVELS];

  // Start index of a tree level
  function automatic logic [31:0] level_start(input int l);
    logic [31:0] s;
    s = '0;
    for (int j = 0; j < MAX_LEVELS; j++) begin
      if (j < l) s = (s << 2) + 32'd1;
    end
    return s;
  endfunction

  assign clearing   = (state_q == ST_CLEAR);
  assign in_stall_o = (state_q != ST_IDLE) || pend_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= LEVELS_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Range check, level decode and entry token
  always_comb begin
    logic [3:0]       act_lv;
    logic [31:0]      in_use;
    logic [31:0]      idx;
    logic [31:0]      base;
    logic [LVL_W-1:0] lvl;
    if (cfg_q == '0) act_lv = 4'd1;
    else if (32'(cfg_q) > MAX_LEVELS) act_lv = 4'(MAX_LEVELS);
    else act_lv = 4'(cfg_q);
    in_use = level_start(1);
    for (int l = 1; l <= MAX_LEVELS; l++) begin
      if (32'(act_lv) == l) in_use = level_start(l);
    end
    idx  = 32'(in_data_i.node_index);
    lvl  = '0;
    base = '0;
    for (int l = 1; l < MAX_LEVELS; l++) begin
      if (idx >= level_start(l)) begin
        lvl  = LVL_W'(l);
        base = level_start(l);
      end
    end
    entry_tok.valid  = accept;
    entry_tok.action = in_data_i.action;
    entry_tok.first  = 1'b1;
    entry_tok.skip   = LVL_W'(MAX_LEVELS - 1) - lvl;
    entry_tok.offset = OFF_W'(idx - base);
    entry_tok.count  = '0;
    entry_tok.err    = (idx >= in_use) ? ERR_RANGE : ERR_OK;
  end

  // Cell chain, one memory per level
  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_lvl
    localparam int AW = (k == 0) ? 1 : 2 * k;
    tok_t                  tok_in;
    logic [OFF_W-1:0]      raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] rdata;

    if (k == MAX_LEVELS - 1) begin : g_entry
      assign tok_in = entry_tok;
    end else begin : g_link
      assign tok_in = chain_out[k+1];
    end

    qtoc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok_in),
      .rdata_i (rdata),
      .raddr_o (raddr),
      .tok_o   (chain_out[k]),
      .wr_o    (cell_wr[k])
    );

    // Clearing pass owns the write port after reset
    assign we    = clearing | cell_wr[k].we;
    assign waddr = clearing ? clr_cnt_q[AW-1:0] : cell_wr[k].addr[AW-1:0];
    assign wdata = clearing ? '0 : cell_wr[k].data;

    qtoc_ram #(
      .DW (COUNT_BITS),
      .AW (AW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (raddr[AW-1:0]),
      .rdata_o (rdata)
    );
  end

  assign res_tok = chain_out[0];

  // Control state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == {OFF_W{1'b1}}) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_BUSY;
      ST_BUSY:  if (res_tok.valid) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + OFF_W'(1);
    end
  end

  // Output register with one buffered result behind it
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (res_tok.valid) begin
      if (!out_valid_q || out_take) out_valid_q <= 1'b1;
      else pend_valid_q <= 1'b1;
    end else if (out_take) begin
      if (pend_valid_q) pend_valid_q <= 1'b0;
      else out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_tok.valid) begin
      if (!out_valid_q || out_take) begin
        out_q.node_count <= res_tok.count;
        out_q.error_code <= res_tok.err;
      end else begin
        pend_q.node_count <= res_tok.count;
        pend_q.error_code <= res_tok.err;
      end
    end else if (out_take && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/qtoc_checker.sv
// qtoc_checker: port-level assertions for the quadtree occupancy counter,
// bound to the top level. Depends on qtoc_pkg.

module qtoc_checker
  import qtoc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_item_t        out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // One transaction in flight: the cycle after an accept is stalled
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  // Errored results report a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error_code != ERR_OK) |-> out_data_o.node_count == '0)
    else $error("errored result with nonzero count");

  // Only defined error codes appear
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.error_code == ERR_OK) ||
                    (out_data_o.error_code == ERR_RANGE) ||
                    (out_data_o.error_code == ERR_EMPTY))
    else $error("undefined error code");

endmodule

bind quadtree_occupancy_counter_unit qtoc_checker u_qtoc_checker (.*);
